@@ hw/rtl/qor_pkg.sv @@
// Shared types, constants and the sequencer step table of the quaternion rotator.
package qor_pkg;

  // Field and datapath widths
  localparam int Q_W      = 16;
  localparam int VEC_W    = 16;
  localparam int ROT_W    = 17;
  localparam int OP_A_W   = 34;
  localparam int OP_B_W   = 16;
  localparam int PROD_W   = OP_A_W + OP_B_W;
  localparam int ACC_W    = 52;
  localparam int STEP_W   = 6;
  localparam int Q_FRAC   = 14;
  localparam int MAT_FRAC = 28;

  // Action codes of the input channel
  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COMPOSE = 2'd1,
    ACT_ROTATE  = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH,
    S_OUT
  } state_t;

  // Multiplier operand A: incoming quaternion, stored quaternion, matrix entries
  typedef enum logic [3:0] {
    A_LX, A_LY, A_LZ, A_LW,
    A_X, A_Y, A_Z, A_W,
    A_E0, A_E1, A_E2
  } asel_t;

  // Multiplier operand B: stored quaternion or vector
  typedef enum logic [2:0] {
    B_X, B_Y, B_Z, B_W,
    B_VX, B_VY, B_VZ
  } bsel_t;

  // Accumulator start value (carries the rounding offset)
  typedef enum logic [1:0] {
    BIAS_ZERO,
    BIAS_HALF_Q,
    BIAS_ONE,
    BIAS_HALF_M
  } bias_t;

  // Where a finished accumulation goes
  typedef enum logic [3:0] {
    D_QX, D_QY, D_QZ, D_QW,
    D_E0, D_E1, D_E2,
    D_RX, D_RY, D_RZ
  } dest_t;

  typedef struct packed {
    logic  vld;
    logic  neg;
    logic  dbl;
    logic  first;
    bias_t bias;
    logic  last;
    dest_t dest;
  } mac_cmd_t;

  typedef struct packed {
    logic  done;
    dest_t dest;
  } mac_res_t;

  typedef struct packed {
    asel_t    a_sel;
    bsel_t    b_sel;
    mac_cmd_t cmd;
    logic     stop;
  } uop_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic commit;
  } seq_stat_t;

  localparam logic [STEP_W-1:0] COMPOSE_START = 6'd0;
  localparam logic [STEP_W-1:0] ROTATE_START  = 6'd18;

  function automatic uop_t uop_mk(asel_t a, bsel_t b, logic neg, logic dbl, logic first,
                                  bias_t bias, logic last, dest_t dest);
    uop_t u;
    u.a_sel     = a;
    u.b_sel     = b;
    u.cmd.vld   = 1'b1;
    u.cmd.neg   = neg;
    u.cmd.dbl   = dbl;
    u.cmd.first = first;
    u.cmd.bias  = bias;
    u.cmd.last  = last;
    u.cmd.dest  = dest;
    u.stop      = 1'b0;
    return u;
  endfunction

  function automatic uop_t uop_first(asel_t a, bsel_t b, logic neg, logic dbl, bias_t bias);
    return uop_mk(a, b, neg, dbl, 1'b1, bias, 1'b0, D_QX);
  endfunction

  function automatic uop_t uop_mid(asel_t a, bsel_t b, logic neg, logic dbl);
    return uop_mk(a, b, neg, dbl, 1'b0, BIAS_ZERO, 1'b0, D_QX);
  endfunction

  function automatic uop_t uop_last(asel_t a, bsel_t b, logic neg, logic dbl, dest_t dest);
    return uop_mk(a, b, neg, dbl, 1'b0, BIAS_ZERO, 1'b1, dest);
  endfunction

  function automatic uop_t uop_nop(logic stop);
    uop_t u;
    u         = uop_mk(A_LX, B_X, 1'b0, 1'b0, 1'b0, BIAS_ZERO, 1'b0, D_QX);
    u.cmd.vld = 1'b0;
    u.stop    = stop;
    return u;
  endfunction

  // Step table. Compose: incoming * stored, one component per group of four.
  // Rotate: per row, three matrix entries (doubled products plus one), two
  // bubbles for the entries to land, then the row dot product with the vector.
  function automatic uop_t uop_rom(logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      // compose x
      6'd0:  u = uop_first(A_LX, B_W, 1'b0, 1'b0, BIAS_HALF_Q);
      6'd1:  u = uop_mid  (A_LY, B_Z, 1'b0, 1'b0);
      6'd2:  u = uop_mid  (A_LZ, B_Y, 1'b1, 1'b0);
      6'd3:  u = uop_last (A_LW, B_X, 1'b0, 1'b0, D_QX);
      // compose y
      6'd4:  u = uop_first(A_LX, B_Z, 1'b1, 1'b0, BIAS_HALF_Q);
      6'd5:  u = uop_mid  (A_LY, B_W, 1'b0, 1'b0);
      6'd6:  u = uop_mid  (A_LZ, B_X, 1'b0, 1'b0);
      6'd7:  u = uop_last (A_LW, B_Y, 1'b0, 1'b0, D_QY);
      // compose z
      6'd8:  u = uop_first(A_LX, B_Y, 1'b0, 1'b0, BIAS_HALF_Q);
      6'd9:  u = uop_mid  (A_LY, B_X, 1'b1, 1'b0);
      6'd10: u = uop_mid  (A_LZ, B_W, 1'b0, 1'b0);
      6'd11: u = uop_last (A_LW, B_Z, 1'b0, 1'b0, D_QZ);
      // compose w
      6'd12: u = uop_first(A_LX, B_X, 1'b1, 1'b0, BIAS_HALF_Q);
      6'd13: u = uop_mid  (A_LY, B_Y, 1'b1, 1'b0);
      6'd14: u = uop_mid  (A_LZ, B_Z, 1'b1, 1'b0);
      6'd15: u = uop_last (A_LW, B_W, 1'b0, 1'b0, D_QW);
      6'd16: u = uop_nop(1'b0);
      6'd17: u = uop_nop(1'b1);
      // row 0 entries: 1-2yy-2zz, 2xy-2wz, 2xz+2wy
      6'd18: u = uop_first(A_Y, B_Y, 1'b1, 1'b1, BIAS_ONE);
      6'd19: u = uop_last (A_Z, B_Z, 1'b1, 1'b1, D_E0);
      6'd20: u = uop_first(A_X, B_Y, 1'b0, 1'b1, BIAS_ZERO);
      6'd21: u = uop_last (A_W, B_Z, 1'b1, 1'b1, D_E1);
      6'd22: u = uop_first(A_X, B_Z, 1'b0, 1'b1, BIAS_ZERO);
      6'd23: u = uop_last (A_W, B_Y, 1'b0, 1'b1, D_E2);
      6'd24: u = uop_nop(1'b0);
      6'd25: u = uop_nop(1'b0);
      6'd26: u = uop_first(A_E0, B_VX, 1'b0, 1'b0, BIAS_HALF_M);
      6'd27: u = uop_mid  (A_E1, B_VY, 1'b0, 1'b0);
      6'd28: u = uop_last (A_E2, B_VZ, 1'b0, 1'b0, D_RX);
      // row 1 entries: 2xy+2wz, 1-2xx-2zz, 2yz-2wx
      6'd29: u = uop_first(A_X, B_Y, 1'b0, 1'b1, BIAS_ZERO);
      6'd30: u = uop_last (A_W, B_Z, 1'b0, 1'b1, D_E0);
      6'd31: u = uop_first(A_X, B_X, 1'b1, 1'b1, BIAS_ONE);
      6'd32: u = uop_last (A_Z, B_Z, 1'b1, 1'b1, D_E1);
      6'd33: u = uop_first(A_Y, B_Z, 1'b0, 1'b1, BIAS_ZERO);
      6'd34: u = uop_last (A_W, B_X, 1'b1, 1'b1, D_E2);
      6'd35: u = uop_nop(1'b0);
      6'd36: u = uop_nop(1'b0);
      6'd37: u = uop_first(A_E0, B_VX, 1'b0, 1'b0, BIAS_HALF_M);
      6'd38: u = uop_mid  (A_E1, B_VY, 1'b0, 1'b0);
      6'd39: u = uop_last (A_E2, B_VZ, 1'b0, 1'b0, D_RY);
      // row 2 entries: 2xz-2wy, 2yz+2wx, 1-2xx-2yy
      6'd40: u = uop_first(A_X, B_Z, 1'b0, 1'b1, BIAS_ZERO);
      6'd41: u = uop_last (A_W, B_Y, 1'b1, 1'b1, D_E0);
      6'd42: u = uop_first(A_Y, B_Z, 1'b0, 1'b1, BIAS_ZERO);
      6'd43: u = uop_last (A_W, B_X, 1'b0, 1'b1, D_E1);
      6'd44: u = uop_first(A_X, B_X, 1'b1, 1'b1, BIAS_ONE);
      6'd45: u = uop_last (A_Y, B_Y, 1'b1, 1'b1, D_E2);
      6'd46: u = uop_nop(1'b0);
      6'd47: u = uop_nop(1'b0);
      6'd48: u = uop_first(A_E0, B_VX, 1'b0, 1'b0, BIAS_HALF_M);
      6'd49: u = uop_mid  (A_E1, B_VY, 1'b0, 1'b0);
      6'd50: u = uop_last (A_E2, B_VZ, 1'b0, 1'b0, D_RZ);
      6'd51: u = uop_nop(1'b0);
      6'd52: u = uop_nop(1'b1);
      default: u = uop_nop(1'b1);
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/qor_mac.sv @@
// Shared two-stage multiply-accumulate unit: registered product, then accumulate.
module qor_mac import qor_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_cmd_t                 cmd_i,
  input  logic signed [OP_A_W-1:0] a_i,
  input  logic signed [OP_B_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  acc_o,
  output mac_res_t                 res_o
);

  localparam logic signed [ACC_W-1:0] ACC_ONE     = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] HALF_Q_VAL  = ACC_ONE <<< (Q_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ONE_M_VAL   = ACC_ONE <<< MAT_FRAC;
  localparam logic signed [ACC_W-1:0] HALF_M_VAL  = ACC_ONE <<< (MAT_FRAC - 1);

  logic signed [PROD_W-1:0] prod_r;
  mac_cmd_t                 cmd1_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  mac_res_t                 res_r;

  // stage 1: product
  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (!rst_n) begin
      cmd1_r <= '0;
    end else begin
      cmd1_r <= cmd_i;
    end
  end

  // stage 2: scale, sign and accumulate
  always_comb begin
    term = ACC_W'(prod_r);
    if (cmd1_r.dbl) begin
      term = term <<< 1;
    end
    if (cmd1_r.neg) begin
      term = -term;
    end
    case (cmd1_r.bias)
      BIAS_ZERO:   base = '0;
      BIAS_HALF_Q: base = HALF_Q_VAL;
      BIAS_ONE:    base = ONE_M_VAL;
      BIAS_HALF_M: base = HALF_M_VAL;
      default:     base = '0;
    endcase
    if (!cmd1_r.first) begin
      base = acc_r;
    end
    acc_nxt = base + term;
  end

  always_ff @(posedge clk) begin
    if (cmd1_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r.done <= cmd1_r.vld & cmd1_r.last;
      res_r.dest <= cmd1_r.dest;
    end
  end

  assign acc_o = acc_r;
  assign res_o = res_r;

endmodule

@@ hw/rtl/qor_seq.sv @@
// Sequencer: handshake control and step counter over the operation table.
module qor_seq import qor_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid_i,
  input  action_t   action_i,
  input  logic      out_ready_i,
  output uop_t      op_o,
  output seq_stat_t stat_o
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  uop_t              rom_op;

  assign rom_op = uop_rom(step_r);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    op_o      = uop_nop(1'b0);
    stat_o    = '0;
    case (state_r)
      S_IDLE: begin
        stat_o.in_ready = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            ACT_COMPOSE: begin
              step_nxt  = COMPOSE_START;
              state_nxt = S_RUN;
            end
            ACT_ROTATE: begin
              step_nxt  = ROTATE_START;
              state_nxt = S_RUN;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_RUN: begin
        op_o = rom_op;
        if (rom_op.stop) begin
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FINISH: begin
        stat_o.commit = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        stat_o.out_valid = 1'b1;
        if (out_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/quaternion_orientation_rotator_unit.sv @@
// Quaternion orientation rotator: top level with operand select and result registers.
//
// Holds an orientation quaternion in Q1.14, identity after reset. One request
// on the in_ channel carries an action and its operands; each request returns
// exactly one result on the out_ channel with the stored quaternion after the
// request and the rotated vector (zero unless the action is rotate).
// Both channels are valid/ready. in_ready is high only while the block is idle,
// so one request is in flight at a time. All products go through one shared
// 34x16 multiply-accumulate unit stepped by a small sequencer.
// Work per request: rotate runs 35 table steps (nine entry groups of two
// products, three dot products of three, and pipeline bubbles), compose runs
// 16 products plus drain, and load or the unused code runs no table steps.
// A new request is taken only once the previous result has been taken.
// The result stays on the out_ ports until taken; a stall on out_ready just
// holds the block in its output state. Synchronous active-low reset returns
// the quaternion to identity and the block to idle; nothing else needs
// clearing.
module quaternion_orientation_rotator_unit import qor_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [Q_W-1:0]   in_quat_x,
  input  logic signed [Q_W-1:0]   in_quat_y,
  input  logic signed [Q_W-1:0]   in_quat_z,
  input  logic signed [Q_W-1:0]   in_quat_w,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [Q_W-1:0]   out_cur_x,
  output logic signed [Q_W-1:0]   out_cur_y,
  output logic signed [Q_W-1:0]   out_cur_z,
  output logic signed [Q_W-1:0]   out_cur_w,
  output logic signed [ROT_W-1:0] out_rot_x,
  output logic signed [ROT_W-1:0] out_rot_y,
  output logic signed [ROT_W-1:0] out_rot_z
);

  localparam logic signed [Q_W-1:0]   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [ROT_W-1:0] ROT_MAX = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0] ROT_MIN = {1'b1, {(ROT_W-1){1'b0}}};
  localparam int QSH_W = ACC_W - Q_FRAC;
  localparam int RSH_W = ACC_W - MAT_FRAC;

  // Round already folded into the accumulator start; floor shift then clamp.
  function automatic logic signed [Q_W-1:0] sat_q(logic signed [ACC_W-1:0] acc);
    logic [QSH_W-1:0] sh;
    sh = acc[ACC_W-1:Q_FRAC];
    if ((&sh[QSH_W-1:Q_W-1]) || !(|sh[QSH_W-1:Q_W-1])) begin
      return sh[Q_W-1:0];
    end else if (sh[QSH_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  function automatic logic signed [ROT_W-1:0] sat_rot(logic signed [ACC_W-1:0] acc);
    logic [RSH_W-1:0] sh;
    sh = acc[ACC_W-1:MAT_FRAC];
    if ((&sh[RSH_W-1:ROT_W-1]) || !(|sh[RSH_W-1:ROT_W-1])) begin
      return sh[ROT_W-1:0];
    end else if (sh[RSH_W-1]) begin
      return ROT_MIN;
    end else begin
      return ROT_MAX;
    end
  endfunction

  function automatic logic signed [OP_A_W-1:0] sx_q(logic signed [Q_W-1:0] v);
    return OP_A_W'(v);
  endfunction

  uop_t                     op;
  seq_stat_t                stat;
  mac_res_t                 mres;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OP_A_W-1:0] mul_a;
  logic signed [OP_B_W-1:0] mul_b;

  // request payload
  action_t                  act_r;
  logic signed [Q_W-1:0]    lx_r, ly_r, lz_r, lw_r;
  logic signed [VEC_W-1:0]  vx_r, vy_r, vz_r;

  // stored orientation, compose results, matrix row, rotated vector
  logic signed [Q_W-1:0]    ox_r, oy_r, oz_r, ow_r;
  logic signed [Q_W-1:0]    nx_r, ny_r, nz_r, nw_r;
  logic signed [OP_A_W-1:0] e0_r, e1_r, e2_r;
  logic signed [ROT_W-1:0]  rx_r, ry_r, rz_r;

  qor_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .action_i    (action_t'(in_action)),
    .out_ready_i (out_ready),
    .op_o        (op),
    .stat_o      (stat)
  );

  qor_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (op.cmd),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .acc_o (acc),
    .res_o (mres)
  );

  // operand select
  always_comb begin
    case (op.a_sel)
      A_LX:    mul_a = sx_q(lx_r);
      A_LY:    mul_a = sx_q(ly_r);
      A_LZ:    mul_a = sx_q(lz_r);
      A_LW:    mul_a = sx_q(lw_r);
      A_X:     mul_a = sx_q(ox_r);
      A_Y:     mul_a = sx_q(oy_r);
      A_Z:     mul_a = sx_q(oz_r);
      A_W:     mul_a = sx_q(ow_r);
      A_E0:    mul_a = e0_r;
      A_E1:    mul_a = e1_r;
      A_E2:    mul_a = e2_r;
      default: mul_a = '0;
    endcase
    case (op.b_sel)
      B_X:     mul_b = ox_r;
      B_Y:     mul_b = oy_r;
      B_Z:     mul_b = oz_r;
      B_W:     mul_b = ow_r;
      B_VX:    mul_b = vx_r;
      B_VY:    mul_b = vy_r;
      B_VZ:    mul_b = vz_r;
      default: mul_b = '0;
    endcase
  end

  // capture request on accept
  always_ff @(posedge clk) begin
    if (in_valid && stat.in_ready) begin
      act_r <= action_t'(in_action);
      lx_r  <= in_quat_x;
      ly_r  <= in_quat_y;
      lz_r  <= in_quat_z;
      lw_r  <= in_quat_w;
      vx_r  <= in_vec_x;
      vy_r  <= in_vec_y;
      vz_r  <= in_vec_z;
    end
  end

  // route finished accumulations
  always_ff @(posedge clk) begin
    if (mres.done) begin
      case (mres.dest)
        D_QX:    nx_r <= sat_q(acc);
        D_QY:    ny_r <= sat_q(acc);
        D_QZ:    nz_r <= sat_q(acc);
        D_QW:    nw_r <= sat_q(acc);
        D_E0:    e0_r <= acc[OP_A_W-1:0];
        D_E1:    e1_r <= acc[OP_A_W-1:0];
        D_E2:    e2_r <= acc[OP_A_W-1:0];
        D_RX:    rx_r <= sat_rot(acc);
        D_RY:    ry_r <= sat_rot(acc);
        D_RZ:    rz_r <= sat_rot(acc);
        default: ;
      endcase
    end else if (stat.commit && act_r != ACT_ROTATE) begin
      rx_r <= '0;
      ry_r <= '0;
      rz_r <= '0;
    end
  end

  // commit new orientation once all results are in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
      ow_r <= Q_W'(1 << Q_FRAC);
    end else if (stat.commit) begin
      case (act_r)
        ACT_LOAD: begin
          ox_r <= lx_r;
          oy_r <= ly_r;
          oz_r <= lz_r;
          ow_r <= lw_r;
        end
        ACT_COMPOSE: begin
          ox_r <= nx_r;
          oy_r <= ny_r;
          oz_r <= nz_r;
          ow_r <= nw_r;
        end
        default: ;
      endcase
    end
  end

  assign in_ready  = stat.in_ready;
  assign out_valid = stat.out_valid;
  assign out_cur_x = ox_r;
  assign out_cur_y = oy_r;
  assign out_cur_z = oz_r;
  assign out_cur_w = ow_r;
  assign out_rot_x = rx_r;
  assign out_rot_y = ry_r;
  assign out_rot_z = rz_r;

endmodule

@@ hw/rtl/qor_checker.sv @@
// Port-level checker for the quaternion rotator and its bind to the top level.
module qor_checker import qor_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              in_action,
  input logic signed [Q_W-1:0]   in_quat_x,
  input logic signed [Q_W-1:0]   in_quat_y,
  input logic signed [Q_W-1:0]   in_quat_z,
  input logic signed [Q_W-1:0]   in_quat_w,
  input logic signed [VEC_W-1:0] in_vec_x,
  input logic signed [VEC_W-1:0] in_vec_y,
  input logic signed [VEC_W-1:0] in_vec_z,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [Q_W-1:0]   out_cur_x,
  input logic signed [Q_W-1:0]   out_cur_y,
  input logic signed [Q_W-1:0]   out_cur_z,
  input logic signed [Q_W-1:0]   out_cur_w,
  input logic signed [ROT_W-1:0] out_rot_x,
  input logic signed [ROT_W-1:0] out_rot_y,
  input logic signed [ROT_W-1:0] out_rot_z
);

  action_t               last_act_r;
  logic signed [Q_W-1:0] ld_x_r, ld_y_r, ld_z_r, ld_w_r;
  logic                  vec_seen;

  // vector ports only matter for rotate; fold them so every port is observed
  assign vec_seen = ^{in_vec_x, in_vec_y, in_vec_z};

  // track the last accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_act_r <= ACT_NOP;
    end else if (in_valid && in_ready) begin
      last_act_r <= action_t'(in_action);
    end
    if (in_valid && in_ready) begin
      ld_x_r <= in_quat_x;
      ld_y_r <= in_quat_y;
      ld_z_r <= in_quat_z;
      ld_w_r <= in_quat_w;
    end
  end

  // after reset: idle, ready for a request, no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // one request at a time: never ready while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while a result is pending");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cur_x) && $stable(out_cur_w)
      && $stable(out_rot_x) && $stable(out_rot_z))
    else $error("result changed under stall");

  // rotated vector is zero for anything but rotate
  a_rot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_act_r != ACT_ROTATE |->
      out_rot_x == '0 && out_rot_y == '0 && out_rot_z == '0 && (vec_seen || !vec_seen))
    else $error("nonzero vector on non-rotate result");

  // load returns the loaded quaternion unchanged
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_act_r == ACT_LOAD |->
      out_cur_x == ld_x_r && out_cur_y == ld_y_r && out_cur_z == ld_z_r
      && out_cur_w == ld_w_r)
    else $error("load result differs from loaded quaternion");

endmodule

bind quaternion_orientation_rotator_unit qor_checker u_qor_checker (.*);

@@ sim/qor_pose_checker.sv @@
// Checker for the quaternion rotator: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module qor_pose_checker import qor_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [Q_W-1:0]   in_quat_x,
  input  logic signed [Q_W-1:0]   in_quat_y,
  input  logic signed [Q_W-1:0]   in_quat_z,
  input  logic signed [Q_W-1:0]   in_quat_w,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [Q_W-1:0]   out_cur_x,
  input  logic signed [Q_W-1:0]   out_cur_y,
  input  logic signed [Q_W-1:0]   out_cur_z,
  input  logic signed [Q_W-1:0]   out_cur_w,
  input  logic signed [ROT_W-1:0] out_rot_x,
  input  logic signed [ROT_W-1:0] out_rot_y,
  input  logic signed [ROT_W-1:0] out_rot_z,
  output int                      mismatches,
  output int                      pending
);

  // One predicted result: stored quaternion and rotated vector
  typedef struct {
    longint cx, cy, cz, cw;
    longint rx, ry, rz;
  } pose_t;

  localparam longint Q_MIN = -32768;
  localparam longint Q_MAX = 32767;
  localparam longint R_MIN = -65536;
  localparam longint R_MAX = 65535;

  // Model copy of the orientation
  longint ori_x, ori_y, ori_z, ori_w;
  pose_t  expected_poses[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input longint want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Round half up at bit sh, then clamp
  function automatic longint round_sat(input longint acc, input int sh,
                                       input longint lo, input longint hi);
    longint r;
    r = (acc + (longint'(1) << (sh - 1))) >>> sh;
    if (r < lo) return lo;
    if (r > hi) return hi;
    return r;
  endfunction

  // Advance the model orientation by one request and return its result
  function automatic pose_t apply_request(input action_t act,
                                          input longint lx, input longint ly,
                                          input longint lz, input longint lw,
                                          input longint vx, input longint vy,
                                          input longint vz);
    pose_t  p;
    longint x, y, z, w, one;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    x = ori_x; y = ori_y; z = ori_z; w = ori_w;
    p.rx = 0; p.ry = 0; p.rz = 0;
    case (act)
      ACT_LOAD: begin
        ori_x = lx; ori_y = ly; ori_z = lz; ori_w = lw;
      end
      // incoming * stored
      ACT_COMPOSE: begin
        ori_x = round_sat( lx * w + ly * z - lz * y + lw * x, Q_FRAC, Q_MIN, Q_MAX);
        ori_y = round_sat(-lx * z + ly * w + lz * x + lw * y, Q_FRAC, Q_MIN, Q_MAX);
        ori_z = round_sat( lx * y - ly * x + lz * w + lw * z, Q_FRAC, Q_MIN, Q_MAX);
        ori_w = round_sat(-lx * x - ly * y - lz * z + lw * w, Q_FRAC, Q_MIN, Q_MAX);
      end
      // rotation matrix in Q.28, exact
      ACT_ROTATE: begin
        one = longint'(1) << MAT_FRAC;
        xx = 2 * x * x; yy = 2 * y * y; zz = 2 * z * z;
        xy = 2 * x * y; xz = 2 * x * z; yz = 2 * y * z;
        wx = 2 * w * x; wy = 2 * w * y; wz = 2 * w * z;
        p.rx = round_sat(vx * (one - yy - zz) + vy * (xy - wz) + vz * (xz + wy),
                         MAT_FRAC, R_MIN, R_MAX);
        p.ry = round_sat(vx * (xy + wz) + vy * (one - xx - zz) + vz * (yz - wx),
                         MAT_FRAC, R_MIN, R_MAX);
        p.rz = round_sat(vx * (xz - wy) + vy * (yz + wx) + vz * (one - xx - yy),
                         MAT_FRAC, R_MIN, R_MAX);
      end
      default: ;
    endcase
    p.cx = ori_x; p.cy = ori_y; p.cz = ori_z; p.cw = ori_w;
    return p;
  endfunction

  // Watch both channels at the clock edge
  always @(posedge clk) begin : watch
    pose_t want;
    if (!rst_n) begin
      ori_x = 0; ori_y = 0; ori_z = 0; ori_w = longint'(1) << Q_FRAC;
      expected_poses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_poses.pop_front();
          check_field("cur_x", out_cur_x, want.cx);
          check_field("cur_y", out_cur_y, want.cy);
          check_field("cur_z", out_cur_z, want.cz);
          check_field("cur_w", out_cur_w, want.cw);
          check_field("rot_x", out_rot_x, want.rx);
          check_field("rot_y", out_rot_y, want.ry);
          check_field("rot_z", out_rot_z, want.rz);
        end
      end
      if (in_valid && in_ready)
        expected_poses.push_back(apply_request(action_t'(in_action),
                                               in_quat_x, in_quat_y, in_quat_z, in_quat_w,
                                               in_vec_x, in_vec_y, in_vec_z));
    end
    pending = expected_poses.size();
  end

endmodule

@@ sim/tb.sv @@
// Top of the quaternion rotator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb import qor_pkg::*;;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_action;
  logic signed [Q_W-1:0]   in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic signed [VEC_W-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [Q_W-1:0]   out_cur_x, out_cur_y, out_cur_z, out_cur_w;
  logic signed [ROT_W-1:0] out_rot_x, out_rot_y, out_rot_z;
  int                      mismatches;
  int                      pending;

  // Idle controls: percent chance of a burst, and no idling at all near the end
  int   src_gap_pct;
  int   sink_stall_pct;
  logic calm;

  localparam int RANDOM_REQUESTS = 800;
  localparam int CALM_TAIL       = 100;

  quaternion_orientation_rotator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_action(in_action),
    .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z),
    .in_quat_w(in_quat_w),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .in_vec_z (in_vec_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cur_x(out_cur_x),
    .out_cur_y(out_cur_y),
    .out_cur_z(out_cur_z),
    .out_cur_w(out_cur_w),
    .out_rot_x(out_rot_x),
    .out_rot_y(out_rot_y),
    .out_rot_z(out_rot_z)
  );

  qor_pose_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_quat_x (in_quat_x),
    .in_quat_y (in_quat_y),
    .in_quat_z (in_quat_z),
    .in_quat_w (in_quat_w),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_vec_z  (in_vec_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cur_x (out_cur_x),
    .out_cur_y (out_cur_y),
    .out_cur_z (out_cur_z),
    .out_cur_w (out_cur_w),
    .out_rot_x (out_rot_x),
    .out_rot_y (out_rot_y),
    .out_rot_z (out_rot_z),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, well beyond the slowest legal run
  initial begin
    #1_500_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Random field value: full range, near unit range, corners or tiny
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 32768)) - 16384);
      2: begin
        case ($urandom_range(0, 4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return 16'sd16384;
          default: return -16'sd16384;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  // Result side: random stall bursts while not calm
  initial begin : result_sink
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!calm && sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 11);
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Present one request at a falling edge and hold it until taken
  task automatic send_request(input action_t act,
                              input logic signed [15:0] qx, input logic signed [15:0] qy,
                              input logic signed [15:0] qz, input logic signed [15:0] qw,
                              input logic signed [15:0] vx, input logic signed [15:0] vy,
                              input logic signed [15:0] vz);
    in_action = act;
    in_quat_x = qx; in_quat_y = qy; in_quat_z = qz; in_quat_w = qw;
    in_vec_x  = vx; in_vec_y  = vy; in_vec_z  = vz;
    in_valid  = 1'b1;
    while (in_ready !== 1'b1) @(negedge clk);
    @(negedge clk);
    // optional sender gap
    if (!calm && src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    action_t act;
    int      r;
    in_valid  = 1'b0;
    in_action = ACT_LOAD;
    in_quat_x = '0; in_quat_y = '0; in_quat_z = '0; in_quat_w = '0;
    in_vec_x  = '0; in_vec_y  = '0; in_vec_z  = '0;
    rst_n          = 1'b0;
    calm           = 1'b0;
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity after reset, vector extremes
    send_request(ACT_ROTATE, 16'sd5, -16'sd5, 16'sd7, 16'sd9,
                 16'sd32767, -16'sd32768, 16'sd1);
    send_request(ACT_ROTATE, '0, '0, '0, '0, -16'sd1, 16'sd0, -16'sd32768);
    // unused code leaves state alone
    send_request(ACT_NOP, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
                 16'sd1234, -16'sd4321, 16'sd77);
    // quarter turn about z, then compose to a half turn
    send_request(ACT_LOAD, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, 16'sd10000, -16'sd20000, 16'sd32767);
    send_request(ACT_COMPOSE, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, 16'sd300, 16'sd200, -16'sd100);
    // zero quaternion: matrix is the identity
    send_request(ACT_LOAD, '0, '0, '0, '0, '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, 16'sd32767, 16'sd32767, -16'sd32768);
    // oversized quaternions saturate the rotated vector
    send_request(ACT_LOAD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, 16'sd32767, 16'sd32767, -16'sd32768);
    send_request(ACT_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                 '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, -16'sd32768, -16'sd32768, -16'sd32768);
    // compose saturates every component
    send_request(ACT_COMPOSE, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                 '0, '0, '0);
    // rounding ties, negative and positive
    send_request(ACT_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd1, '0, '0, '0);
    send_request(ACT_COMPOSE, 16'sd0, 16'sd0, 16'sd0, -16'sd8192, '0, '0, '0);
    send_request(ACT_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd1, '0, '0, '0);
    send_request(ACT_COMPOSE, 16'sd0, 16'sd0, 16'sd0, 16'sd8192, '0, '0, '0);
    // third of a turn about the diagonal
    send_request(ACT_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, '0, '0, '0);
    send_request(ACT_COMPOSE, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, '0, '0, '0);
    send_request(ACT_ROTATE, '0, '0, '0, '0, 16'sd1, 16'sd2, 16'sd3);
    drain_results();

    // Random: loads, compose chains, rotations, some unused codes
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) begin
        src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (i % 150 == 149) drain_results();
      if (i == RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 25)      act = ACT_LOAD;
      else if (r < 55) act = ACT_COMPOSE;
      else if (r < 92) act = ACT_ROTATE;
      else             act = ACT_NOP;
      send_request(act, pick_value(), pick_value(), pick_value(), pick_value(),
                   pick_value(), pick_value(), pick_value());
    end

    // Wind down and give the verdict
    calm     = 1'b1;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
